// File: src/chrl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and codes of the consistent-hashing ring lookup block.
// No dependencies; imported by the top level.
package chrl_pkg;

   // Command codes carried on the request channel.
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_LOAD   = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_LOOKUP = 2'd3;

   // Status codes carried on the response channel.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // Register file: one register at byte address 0.
   localparam int unsigned CSR_ADDR_W      = 3;
   localparam int unsigned CSR_DATA_W      = 32;
   localparam logic        REG_OWN_NODE_ID = 1'b0;

   // One ring entry as stored in the table memory.
   typedef struct packed {
      logic [63:0] position;
      logic [7:0]  owner;
      logic        in_new_ring;
   } ring_entry_type;

endpackage
`default_nettype wire

// File: src/consistent_hash_ring_lookup_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Consistent-hashing ring lookup: a table of ring positions with owners, kept in one RAM.
// Depends on chrl_pkg and chrl_ram.
// Every command scans the valid entries once through the single RAM read port; an empty table
// or a clear leaves nothing to scan. One item is worked on at a time: the next request is
// taken only after the response of the last one is registered, and later while a stalled
// result blocks the end of the scan.
// Synchronous active-high reset empties the table (entry count zero) and sets own_node_id
// to zero; the RAM contents are not cleared, since entries at or above the count are unread.
module consistent_hash_ring_lookup_top
   import chrl_pkg::*;
#(
   parameter int unsigned RING_SIZE = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_cmd,
   input  wire logic [63:0]           req_key,
   input  wire logic [7:0]            req_node,
   input  wire logic                  req_ring_select,
   // Response channel.
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [1:0]            rsp_status,
   output logic      [7:0]            rsp_owner_node,
   output logic                       rsp_is_own,
   // Register port.
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   // The count must hold RING_SIZE itself; a RAM index only needs RING_SIZE - 1.
   localparam int unsigned CNT_W   = $clog2(RING_SIZE + 1);
   localparam int unsigned IDX_W   = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;
   localparam int unsigned ENTRY_W = $bits(ring_entry_type);
   localparam logic [CNT_W-1:0] RING_MAX = CNT_W'(RING_SIZE);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0] rd_pidx_ff, rd_pidx_in;

   // Latched request.
   logic [1:0]  cmd_ff, cmd_in;
   logic [63:0] key_ff, key_in;
   logic [7:0]  node_ff, node_in;
   logic        sel_old_ff, sel_old_in;

   // Scan accumulators.
   logic             any_ff, any_in;
   logic             below_ff, below_in;
   logic [63:0]      max_pos_ff, max_pos_in;
   logic [7:0]       max_own_ff, max_own_in;
   logic [63:0]      best_pos_ff, best_pos_in;
   logic [7:0]       best_own_ff, best_own_in;
   logic             match_ff, match_in;
   logic [IDX_W-1:0] match_idx_ff, match_idx_in;

   // Output register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [7:0] rsp_owner_ff, rsp_owner_in;
   logic       rsp_is_own_ff, rsp_is_own_in;

   logic [7:0] own_id_ff, own_id_in;

   // RAM port signals.
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   ring_entry_type     ram_wr_entry;
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   ring_entry_type     rd_entry;
   logic               out_free;
   logic               csr_write;
   logic               entry_hit;
   logic [7:0]         found_owner;

   chrl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (RING_SIZE)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_entry = ring_entry_type'(ram_rd_data);

   // Register port: always ready, a write lands in the access phase.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_W-1:2] == REG_OWN_NODE_ID) begin
         csr_prdata = CSR_DATA_W'(own_id_ff);
      end
   end

   // A new request is taken only between scans; the response register keeps the
   // previous result for the downstream side in the meantime.
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_owner_node = rsp_owner_ff;
   assign rsp_is_own     = rsp_is_own_ff;

   // An entry takes part in a lookup if the old ring is chosen or it is still in the new ring.
   assign entry_hit   = sel_old_ff || rd_entry.in_new_ring;
   assign found_owner = below_ff ? best_own_ff : max_own_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rd_idx_in     = rd_idx_ff;
      rd_pend_in    = rd_pend_ff;
      rd_pidx_in    = rd_pidx_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      node_in       = node_ff;
      sel_old_in    = sel_old_ff;
      any_in        = any_ff;
      below_in      = below_ff;
      max_pos_in    = max_pos_ff;
      max_own_in    = max_own_ff;
      best_pos_in   = best_pos_ff;
      best_own_in   = best_own_ff;
      match_in      = match_ff;
      match_idx_in  = match_idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_owner_in  = rsp_owner_ff;
      rsp_is_own_in = rsp_is_own_ff;
      own_id_in     = own_id_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = '0;
      ram_wr_entry  = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = rd_idx_ff[IDX_W-1:0];

      if (csr_write && (csr_paddr[CSR_ADDR_W-1:2] == REG_OWN_NODE_ID)) begin
         own_id_in = csr_pwdata[7:0];
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_cmd;
               key_in     = req_key;
               node_in    = req_node;
               sel_old_in = req_ring_select;
               rd_idx_in  = '0;
               rd_pend_in = 1'b0;
               any_in     = 1'b0;
               below_in   = 1'b0;
               match_in   = 1'b0;
               // A clear empties the table at once; its scan then ends immediately.
               if (req_cmd == CMD_CLEAR) begin
                  cnt_in = '0;
               end
               state_in = S_SCAN;
            end
         end

         S_SCAN: begin
            // Read side: one entry address per cycle while entries remain.
            if (rd_idx_ff < cnt_ff) begin
               ram_rd_en  = 1'b1;
               rd_idx_in  = rd_idx_ff + CNT_W'(1);
               rd_pend_in = 1'b1;
               rd_pidx_in = rd_idx_ff[IDX_W-1:0];
            end else begin
               rd_pend_in = 1'b0;
            end

            // Evaluate the entry read in the previous cycle.
            if (rd_pend_ff) begin
               case (cmd_ff)
                  CMD_LOAD: begin
                     if (!match_ff && (rd_entry.position == key_ff)) begin
                        match_in     = 1'b1;
                        match_idx_in = rd_pidx_ff;
                     end
                  end
                  CMD_REMOVE: begin
                     // Write back behind the read pointer, so no read sees a stale entry.
                     if (rd_entry.owner == node_ff) begin
                        ram_wr_en                = 1'b1;
                        ram_wr_addr              = rd_pidx_ff;
                        ram_wr_entry             = rd_entry;
                        ram_wr_entry.in_new_ring = 1'b0;
                     end
                  end
                  CMD_LOOKUP: begin
                     if (entry_hit) begin
                        any_in = 1'b1;
                        if (!any_ff || (rd_entry.position > max_pos_ff)) begin
                           max_pos_in = rd_entry.position;
                           max_own_in = rd_entry.owner;
                        end
                        if ((rd_entry.position <= key_ff) &&
                            (!below_ff || (rd_entry.position > best_pos_ff))) begin
                           below_in    = 1'b1;
                           best_pos_in = rd_entry.position;
                           best_own_in = rd_entry.owner;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end

            // End of scan: deliver the result once the output register is free.
            if ((rd_idx_ff == cnt_ff) && !rd_pend_ff && out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_owner_in  = '0;
               rsp_is_own_in = 1'b0;
               case (cmd_ff)
                  CMD_LOAD: begin
                     ram_wr_entry.position    = key_ff;
                     ram_wr_entry.owner       = node_ff;
                     ram_wr_entry.in_new_ring = 1'b1;
                     if (match_ff) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = match_idx_ff;
                     end else if (cnt_ff < RING_MAX) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = cnt_ff[IDX_W-1:0];
                        cnt_in      = cnt_ff + CNT_W'(1);
                     end else begin
                        rsp_status_in = STATUS_FULL;
                     end
                  end
                  CMD_LOOKUP: begin
                     if (!any_ff) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        rsp_owner_in  = found_owner;
                        rsp_is_own_in = (found_owner == own_id_ff);
                     end
                  end
                  default: begin
                  end
               endcase
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         own_id_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         own_id_ff    <= own_id_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      rd_pidx_ff    <= rd_pidx_in;
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      node_ff       <= node_in;
      sel_old_ff    <= sel_old_in;
      any_ff        <= any_in;
      below_ff      <= below_in;
      max_pos_ff    <= max_pos_in;
      max_own_ff    <= max_own_in;
      best_pos_ff   <= best_pos_in;
      best_own_ff   <= best_own_in;
      match_ff      <= match_in;
      match_idx_ff  <= match_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_owner_ff  <= rsp_owner_in;
      rsp_is_own_ff <= rsp_is_own_in;
   end

endmodule
`default_nettype wire

// File: src/chrl_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module chrl_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire
